@@ design/sms_pkg.sv @@
package sms_pkg;

	// input item kinds, carried on s_axis_tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	// fixed field widths
	localparam int unsigned STEP_COUNT_W = 24;
	localparam int unsigned PERIOD_W     = 24;
	localparam int unsigned COIL_W       = 4;

	// full-step two-coil drive, bit0..bit3 = coils 1..4
	localparam logic [COIL_W-1:0] PHASE_COILS [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

	typedef struct packed {
		logic              move_done;
		logic              running;
		logic [COIL_W-1:0] coil_pattern;
	} result_t;

endpackage

@@ design/stepper_move_sequencer_unit.sv @@
// the result of an accepted input transaction is registered and shows on m_axis in the next cycle
// throughput: one transaction per cycle unless m_axis stalls; the whole state update for an item is one
//   registered step, and the result register frees itself as it is taken downstream
// reset (arst_n low, asynchronous): motor idle, coils released, phase 0, direction
//   clockwise, timer and step count zero, step period 1953, no result pending
module stepper_move_sequencer_unit #(
	parameter int COUNT_BITS = 24,
	parameter int TIMER_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// step period register write
	input  logic                              cfg_wr_en,
	input  logic [sms_pkg::PERIOD_W-1:0]      cfg_wr_data,
	// input items
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,  // [23:0] step_count, [24] clockwise
	input  logic [1:0]                        s_axis_tuser,  // [1:0] opcode
	// results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata   // [3:0] coil_pattern, [4] running,
	                                                         // [5] move_done
);

	// working widths that cover both the 24-bit fields and the parameters
	localparam int CW = (COUNT_BITS > sms_pkg::STEP_COUNT_W) ? COUNT_BITS
	                                                          : sms_pkg::STEP_COUNT_W;
	localparam int TW = (TIMER_BITS > sms_pkg::PERIOD_W) ? TIMER_BITS : sms_pkg::PERIOD_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
	localparam logic [sms_pkg::PERIOD_W-1:0] PERIOD_RESET = 24'd1953;

	// -------------------------------------------------------------------------
	// state
	// -------------------------------------------------------------------------
	logic [sms_pkg::PERIOD_W-1:0] step_period_q;
	logic                         active_q;
	logic [COUNT_BITS-1:0]        steps_left_q;
	logic                         forward_q;
	logic [1:0]                   phase_q;
	logic [TIMER_BITS-1:0]        timer_q;
	logic [sms_pkg::COIL_W-1:0]   coil_q;

	// result register
	logic                         m_valid_q;
	sms_pkg::result_t             m_data_q;

	// -------------------------------------------------------------------------
	// input field unpacking
	// -------------------------------------------------------------------------
	logic [1:0]                       opcode;
	logic [sms_pkg::STEP_COUNT_W-1:0] step_count;
	logic                             clockwise;
	logic                             in_xfer;

	assign opcode     = s_axis_tuser;
	assign step_count = s_axis_tdata[sms_pkg::STEP_COUNT_W-1:0];
	assign clockwise  = s_axis_tdata[sms_pkg::STEP_COUNT_W];

	// take a new item whenever the result register is empty or being drained
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// -------------------------------------------------------------------------
	// start: magnitude of the signed count, saturated to the counter width
	// -------------------------------------------------------------------------
	logic [sms_pkg::STEP_COUNT_W-1:0] mag;
	logic [CW-1:0]                    mag_ext;
	logic [COUNT_BITS-1:0]            start_count;

	always_comb begin
		mag     = step_count[sms_pkg::STEP_COUNT_W-1] ? (~step_count + 1'b1) : step_count;
		mag_ext = CW'(mag);
		if (mag_ext > CW'(COUNT_MAX)) begin
			start_count = COUNT_MAX;
		end else begin
			start_count = mag_ext[COUNT_BITS-1:0];
		end
	end

	// -------------------------------------------------------------------------
	// tick: saturating timer, compare against period (zero acts as one)
	// -------------------------------------------------------------------------
	logic [TIMER_BITS-1:0]        timer_inc;
	logic [TW-1:0]                period_ext;
	logic [TW-1:0]                timer_ext;
	logic                         step_due;
	logic [TIMER_BITS-1:0]        timer_after_step;
	logic [1:0]                   phase_step;
	logic [COUNT_BITS-1:0]        steps_dec;

	always_comb begin
		timer_inc  = (timer_q == TIMER_MAX) ? timer_q : timer_q + 1'b1;
		period_ext = (step_period_q == '0) ? TW'(1) : TW'(step_period_q);
		timer_ext  = TW'(timer_inc);
		step_due   = timer_ext >= period_ext;
		// when a step is due the difference never exceeds timer_inc, so it fits the timer width
		timer_after_step = TIMER_BITS'(timer_ext - period_ext);
		phase_step = forward_q ? phase_q + 2'd1 : phase_q - 2'd1;
		steps_dec  = (steps_left_q != '0) ? steps_left_q - 1'b1 : steps_left_q;
	end

	// -------------------------------------------------------------------------
	// next state and result for the item at the input
	// -------------------------------------------------------------------------
	logic                         active_d;
	logic [COUNT_BITS-1:0]        steps_left_d;
	logic                         forward_d;
	logic [1:0]                   phase_d;
	logic [TIMER_BITS-1:0]        timer_d;
	logic [sms_pkg::COIL_W-1:0]   coil_d;
	logic                         done_d;

	always_comb begin
		active_d     = active_q;
		steps_left_d = steps_left_q;
		forward_d    = forward_q;
		phase_d      = phase_q;
		timer_d      = timer_q;
		coil_d       = coil_q;
		done_d       = 1'b0;
		case (opcode)
			sms_pkg::OP_TICK: begin
				// idle ticks leave the timer alone
				if (active_q) begin
					timer_d = timer_inc;
					if (step_due) begin
						timer_d      = timer_after_step;
						phase_d      = phase_step;
						coil_d       = sms_pkg::PHASE_COILS[phase_step];
						steps_left_d = steps_dec;
						if (steps_dec == '0) begin
							// final step taken: release coils
							active_d = 1'b0;
							coil_d   = '0;
							done_d   = 1'b1;
						end
					end
				end
			end
			sms_pkg::OP_START: begin
				// replaces any move in progress; phase and coils carry over
				steps_left_d = start_count;
				forward_d    = clockwise;
				timer_d      = '0;
				active_d     = (start_count != '0);
			end
			sms_pkg::OP_STOP: begin
				// phase and timer are kept
				active_d     = 1'b0;
				steps_left_d = '0;
				coil_d       = '0;
			end
			default: begin
				// unused code: state unchanged, result reports it
			end
		endcase
	end

	// -------------------------------------------------------------------------
	// registers
	// -------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= PERIOD_RESET;
		end else if (cfg_wr_en) begin
			step_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			steps_left_q <= '0;
			forward_q    <= 1'b1;
			phase_q      <= 2'd0;
			timer_q      <= '0;
			coil_q       <= '0;
		end else if (in_xfer) begin
			active_q     <= active_d;
			steps_left_q <= steps_left_d;
			forward_q    <= forward_d;
			phase_q      <= phase_d;
			timer_q      <= timer_d;
			coil_q       <= coil_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			m_valid_q <= s_axis_tvalid;
		end
	end

	// payload only moves with a transaction, so a stalled result holds
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_data_q.coil_pattern <= coil_d;
			m_data_q.running      <= active_d;
			m_data_q.move_done    <= done_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_data_q};

	// -------------------------------------------------------------------------
	// assertions
	// -------------------------------------------------------------------------
	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_data_q.move_done) |-> (!m_data_q.running && m_data_q.coil_pattern == '0))
		else $error("move_done reported with motor still driven");

	a_running_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (steps_left_q != '0))
		else $error("running with no steps left");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> m_valid_q)
		else $error("accepted transaction produced no result");

	a_idle_timer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !active_q && opcode == sms_pkg::OP_TICK) |=> $stable(timer_q))
		else $error("timer moved on an idle tick");

endmodule

@@ verif/move_sequence_checker.sv @@
`timescale 1ns / 100ps

module move_sequence_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [23:0] step_count, [24] clockwise
	input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // [3:0] coil_pattern, [4] running, [5] move_done
	output int          mismatch_count,
	output int          expected_left
);

	localparam logic [23:0] PERIOD_AT_RESET = 24'd1953;

	typedef struct {
		logic        active;
		logic [23:0] steps_left;
		logic        forward;
		logic [1:0]  phase;
		logic [23:0] timer;
		logic [3:0]  coils;
	} motor_t;

	motor_t           motor;
	logic [23:0]      period_copy;
	sms_pkg::result_t expected_drive_q [$];

	// one item applied to the motor state, drive seen after it
	function automatic motor_t advance_motor(input motor_t st, input logic [1:0] op,
			input logic [23:0] count, input logic cw, input logic [23:0] period,
			output sms_pkg::result_t drive);
		logic [23:0] eff;
		logic [23:0] mag;
		logic        done;
		done = 1'b0;
		case (op)
			sms_pkg::OP_TICK: begin
				if (st.active) begin
					eff = (period == '0) ? 24'd1 : period;
					if (st.timer != '1)
						st.timer = st.timer + 24'd1;
					if (st.timer >= eff) begin
						st.timer = st.timer - eff;
						st.phase = st.forward ? st.phase + 2'd1 : st.phase - 2'd1;
						st.coils = sms_pkg::PHASE_COILS[st.phase];
						if (st.steps_left != '0)
							st.steps_left = st.steps_left - 24'd1;
						if (st.steps_left == '0) begin
							st.active = 1'b0;
							st.coils  = '0;
							done      = 1'b1;
						end
					end
				end
			end
			sms_pkg::OP_START: begin
				mag           = count[23] ? (~count + 24'd1) : count;
				st.steps_left = mag;
				st.forward    = cw;
				st.timer      = '0;
				st.active     = (mag != '0);
			end
			sms_pkg::OP_STOP: begin
				st.active     = 1'b0;
				st.steps_left = '0;
				st.coils      = '0;
			end
			default: ;
		endcase
		drive.coil_pattern = st.coils;
		drive.running      = st.active;
		drive.move_done    = done;
		return st;
	endfunction

	assign expected_left = expected_drive_q.size();

	always @(posedge clk) begin
		sms_pkg::result_t want;
		sms_pkg::result_t got;
		if (!arst_n) begin
			motor.active     = 1'b0;
			motor.steps_left = '0;
			motor.forward    = 1'b1;
			motor.phase      = '0;
			motor.timer      = '0;
			motor.coils      = '0;
			period_copy      = PERIOD_AT_RESET;
			mismatch_count   = 0;
			expected_drive_q.delete();
		end else begin
			if (cfg_wr_en)
				period_copy = cfg_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got = sms_pkg::result_t'(m_axis_tdata[5:0]);
				if (expected_drive_q.size() == 0) begin
					$error("result with no expectation waiting: tdata %0h", m_axis_tdata);
					mismatch_count++;
				end else begin
					want = expected_drive_q.pop_front();
					if (got.coil_pattern !== want.coil_pattern) begin
						$error("coil_pattern: expected %0h, actual %0h",
							want.coil_pattern, got.coil_pattern);
						mismatch_count++;
					end
					if (got.running !== want.running) begin
						$error("running: expected %0b, actual %0b", want.running, got.running);
						mismatch_count++;
					end
					if (got.move_done !== want.move_done) begin
						$error("move_done: expected %0b, actual %0b",
							want.move_done, got.move_done);
						mismatch_count++;
					end
					if (m_axis_tdata[7:6] !== 2'b00) begin
						$error("pad: expected 0, actual %0h", m_axis_tdata[7:6]);
						mismatch_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				motor = advance_motor(motor, s_axis_tuser, s_axis_tdata[23:0],
					s_axis_tdata[24], period_copy, want);
				expected_drive_q.push_back(want);
			end
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

	// opcode the block must treat as a no-op
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int MAX_ITEM_VALUE = 8388607;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [23:0] step_count, [24] clockwise
	logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [3:0] coil_pattern, [4] running, [5] move_done

	int   mismatch_count;
	int   expected_left;
	int   items_sent = 0;
	// calm flags switch off random gaps for whole phases
	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	int   rx_hold = 0;

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	stepper_move_sequencer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	move_sequence_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.expected_left  (expected_left)
	);

	// receiver back-pressure: mostly short stalls, a few long ones
	always @(negedge clk) begin
		int r;
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!rx_calm) begin
				r = $urandom_range(0, 99);
				if (r < 20)
					rx_hold = $urandom_range(1, 3);
				else if (r < 23)
					rx_hold = $urandom_range(10, 40);
			end
		end
	end

	// idle cycles before the next input transaction
	function automatic int pick_gap();
		int r;
		if (tx_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one input transaction; returns at the edge that accepts it
	task automatic send_item(input logic [1:0] op, input logic [23:0] count, input logic cw);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, cw, count};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// tick with junk in the ignored fields
	task automatic send_tick();
		send_item(sms_pkg::OP_TICK, 24'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// hold off the sender until every result is back, then wait out the result register
	task automatic wait_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_left != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// period write only with the stream idle; the motor itself may still be mid-move
	task automatic write_period(input logic [23:0] value);
		wait_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// start a move and feed ticks, roughly enough to finish a short move at a short period, with some noise mixed in
	task automatic run_move(input logic [23:0] period);
		int unsigned n;
		int unsigned eff;
		int          ticks;
		int          r;
		logic [23:0] count;
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(1, MAX_ITEM_VALUE);
		else
			n = $urandom_range(1, 8);
		count = 24'(n);
		if ($urandom_range(0, 1))
			count = -count;
		send_item(sms_pkg::OP_START, count, 1'($urandom_range(0, 1)));
		eff = (period == '0) ? 32'd1 : 32'(period);
		if (n <= 8 && eff <= 16)
			ticks = n * eff + $urandom_range(0, 3);
		else
			ticks = $urandom_range(4, 30);
		for (int i = 0; i < ticks; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				send_item(sms_pkg::OP_STOP, 24'($urandom), 1'($urandom_range(0, 1)));
			else if (r < 4)
				send_item(OP_UNUSED, 24'($urandom), 1'($urandom_range(0, 1)));
			else if (r < 5)
				send_item(sms_pkg::OP_START, 24'($urandom),
					1'($urandom_range(0, 1)));  // restart mid-move
			else
				send_tick();
		end
	endtask

	task automatic random_phase(input logic [23:0] period, input int budget);
		int stop_at;
		int r;
		write_period(period);
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				run_move(period);
			else if (r < 82)
				send_item(sms_pkg::OP_STOP, 24'($urandom), 1'($urandom_range(0, 1)));
			else if (r < 88)
				send_item(OP_UNUSED, 24'($urandom), 1'($urandom_range(0, 1)));
			else if (r < 91)
				wait_results();
			else
				repeat ($urandom_range(1, 6)) send_tick();
		end
	endtask

	// run limit, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int waited;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset period is long: no step may land within the first few dozen ticks
		tx_calm = 1'b1;
		send_item(sms_pkg::OP_START, 24'd1, 1'b1);
		repeat (20) send_tick();
		send_item(sms_pkg::OP_STOP, 24'd0, 1'b0);
		tx_calm = 1'b0;

		// directed corners at a short period
		write_period(24'd2);
		send_item(OP_UNUSED, 24'h7FFFFF, 1'b1);          // no-op while idle
		send_tick();                                     // tick while idle
		send_item(sms_pkg::OP_START, 24'd0, 1'b0);       // zero count never runs
		send_item(sms_pkg::OP_START, 24'h7FFFFF, 1'b1);  // largest positive count
		repeat (3) send_tick();
		send_item(sms_pkg::OP_START, 24'h800000, 1'b0);  // most negative count replaces move
		repeat (4) send_tick();
		send_item(OP_UNUSED, 24'h000000, 1'b0);          // no-op during a move
		send_item(sms_pkg::OP_STOP, 24'hFFFFFF, 1'b1);
		send_item(sms_pkg::OP_START, -24'sd3, 1'b0);     // short backward move to completion
		repeat (6) send_tick();
		send_item(sms_pkg::OP_START, 24'd5, 1'b1);
		repeat (2) send_tick();
		send_item(sms_pkg::OP_START, 24'd0, 1'b1);       // zero count leaves coils energized
		send_tick();
		send_item(sms_pkg::OP_STOP, 24'd0, 1'b0);

		// period shortened while the motor is mid-move: timer surplus steps out tick by tick
		write_period(24'd40);
		send_item(sms_pkg::OP_START, 24'd4, 1'b0);
		repeat (30) send_tick();
		write_period(24'd3);
		repeat (20) send_tick();

		// random phases across period settings, extremes included
		random_phase(24'd1, 150);
		random_phase(24'd0, 120);
		random_phase(24'd2, 150);
		random_phase(24'd3, 150);
		random_phase(24'd5, 120);
		random_phase(24'($urandom_range(1, 12)), 130);
		random_phase(24'hFFFFFF, 60);
		random_phase(24'($urandom_range(1, 24'hFFFFFF)), 60);

		// drain with a bound, then allow for the result register latency
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (expected_left != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		if (expected_left != 0) begin
			$display("status: fail");
			$finish;
		end else begin
			repeat (8) @(posedge clk);
			if (mismatch_count == 0 && expected_left == 0)
				$display("status: pass");
			else
				$display("status: fail");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
design/sms_pkg.sv
design/stepper_move_sequencer_unit.sv
verif/move_sequence_checker.sv
verif/tb.sv
